FILE: design/wmmd_pkg.sv
// Shared types and constants for the waveform min/max decimator.
// No dependencies; the top level refers to it by scoped names.
package wmmd_pkg;

    // Default width of the sample position counter.
    localparam int unsigned POSITION_BITS_DEFAULT = 24;
    // Width of the position field on the result stream.
    localparam int unsigned OUT_POS_W = 24;
    // Width of a sample and of the segment length register.
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned SEG_LEN_W = 16;
    // Segment length after reset.
    localparam logic [SEG_LEN_W-1:0] SEG_LEN_RESET = 16'd1;

    // One extreme point as it leaves the block.
    typedef struct packed {
        logic [OUT_POS_W-1:0]       position;
        logic signed [SAMPLE_W-1:0] value;
        logic                       is_maximum;
        logic                       last_of_run;
        logic                       stream_done;
    } point_t;

endpackage

FILE: design/waveform_minmax_decimator.sv
// Waveform min/max decimator: top level.
// Depends on wmmd_pkg for the point type, field widths and reset constants.
//
// Takes one signed 16-bit sample per cycle (unless stalled) and splits the stream into
// segments of segment_length samples (0 counts as 1); tlast on a sample ends the data
// and closes the segment early. For each closed segment the block sends the minimum and
// maximum points in stream order, or one point (the minimum, is_maximum 0) when both sit at
// the same position. Ties keep the earliest position. Positions count from 0,
// saturate at 2^POSITION_BITS-1 and restart after the last sample. A sample is
// registered at its transfer and folded into the running extremes when it advances.
// When it closes a segment, its points enter a two-point output buffer at that same edge,
// so the first point is valid once the closing sample has passed the input register and
// head_reg. The buffer drains one point per cycle while m_axis_tready is high. Throughput
// is one sample per cycle while m_axis_tready stays high; a segment of one sample closed
// by tlast while the previous pair is still draining stalls input.
module waveform_minmax_decimator #(
    parameter int unsigned POSITION_BITS = wmmd_pkg::POSITION_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // segment length register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,   // end_of_data
    // extreme point stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [23:0] position, [39:24] value
    output logic        m_axis_tlast,   // last_of_run
    output logic [1:0]  m_axis_tuser    // [0] is_maximum, [1] stream_done
);

    localparam int unsigned SW = wmmd_pkg::SAMPLE_W;
    localparam int unsigned LW = wmmd_pkg::SEG_LEN_W;
    localparam int unsigned OPW = wmmd_pkg::OUT_POS_W;

    logic [LW-1:0] seg_len_reg;

    logic                 in_valid_reg;
    logic signed [SW-1:0] in_sample_reg;
    logic                 in_eod_reg;

    logic [POSITION_BITS-1:0] sample_pos_reg;
    logic [LW-1:0]            fill_reg;
    logic signed [SW-1:0]     max_reg;
    logic signed [SW-1:0]     min_reg;
    logic [POSITION_BITS-1:0] max_pos_reg;
    logic [POSITION_BITS-1:0] min_pos_reg;

    logic signed [SW-1:0]     max_next;
    logic signed [SW-1:0]     min_next;
    logic [POSITION_BITS-1:0] max_pos_next;
    logic [POSITION_BITS-1:0] min_pos_next;
    logic [LW-1:0]            fill_inc;
    logic [LW-1:0]            eff_len;
    logic                     seg_close;

    logic [POSITION_BITS+OPW-1:0] max_pos_ext;
    logic [POSITION_BITS+OPW-1:0] min_pos_ext;
    wmmd_pkg::point_t max_pt;
    wmmd_pkg::point_t min_pt;
    wmmd_pkg::point_t p0;
    wmmd_pkg::point_t p1;
    logic [1:0]       n_points;

    wmmd_pkg::point_t head_reg;
    wmmd_pkg::point_t head_next;
    wmmd_pkg::point_t second_reg;
    wmmd_pkg::point_t second_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    logic s_accept;
    logic in_advance;
    logic buf_free;
    logic pop;
    logic push;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_len_reg <= wmmd_pkg::SEG_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            seg_len_reg <= cfg_data;
        end
    end

    // ---------------- handshakes ----------------
    assign pop      = m_axis_tvalid && m_axis_tready;
    assign buf_free = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_axis_tready);

    // advance the held sample unless it closes a segment and the buffer has no room
    assign in_advance    = in_valid_reg && (!seg_close || buf_free);
    assign push          = in_advance && seg_close;
    assign s_axis_tready = !in_valid_reg || in_advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (in_advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_sample_reg <= s_axis_tdata;
            in_eod_reg    <= s_axis_tlast;
        end
    end

    // ---------------- running extremes ----------------
    always_comb
    begin
        max_next     = max_reg;
        min_next     = min_reg;
        max_pos_next = max_pos_reg;
        min_pos_next = min_pos_reg;
        if (fill_reg == '0)
        begin
            max_next     = in_sample_reg;
            min_next     = in_sample_reg;
            max_pos_next = sample_pos_reg;
            min_pos_next = sample_pos_reg;
        end
        else
        begin
            if (in_sample_reg > max_reg)
            begin
                max_next     = in_sample_reg;
                max_pos_next = sample_pos_reg;
            end
            if (in_sample_reg < min_reg)
            begin
                min_next     = in_sample_reg;
                min_pos_next = sample_pos_reg;
            end
        end
    end

    assign fill_inc  = (fill_reg == '1) ? fill_reg : fill_reg + 1'b1;
    assign eff_len   = (seg_len_reg == '0) ? LW'(1) : seg_len_reg;
    assign seg_close = (fill_inc >= eff_len) || in_eod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_pos_reg <= '0;
            fill_reg       <= '0;
            max_reg        <= '0;
            min_reg        <= '0;
            max_pos_reg    <= '0;
            min_pos_reg    <= '0;
        end
        else if (in_advance)
        begin
            max_reg     <= max_next;
            min_reg     <= min_next;
            max_pos_reg <= max_pos_next;
            min_pos_reg <= min_pos_next;
            fill_reg    <= seg_close ? '0 : fill_inc;
            if (in_eod_reg)
            begin
                sample_pos_reg <= '0;
            end
            else if (sample_pos_reg != '1)
            begin
                sample_pos_reg <= sample_pos_reg + 1'b1;
            end
        end
    end

    // ---------------- point ordering ----------------
    assign max_pos_ext = {{OPW{1'b0}}, max_pos_next};
    assign min_pos_ext = {{OPW{1'b0}}, min_pos_next};

    always_comb
    begin
        max_pt.position    = max_pos_ext[OPW-1:0];
        max_pt.value       = max_next;
        max_pt.is_maximum  = 1'b1;
        max_pt.last_of_run = 1'b0;
        max_pt.stream_done = in_eod_reg;
        min_pt.position    = min_pos_ext[OPW-1:0];
        min_pt.value       = min_next;
        min_pt.is_maximum  = 1'b0;
        min_pt.last_of_run = 1'b0;
        min_pt.stream_done = in_eod_reg;

        if (max_pos_next > min_pos_next)
        begin
            p0             = min_pt;
            p1             = max_pt;
            p1.last_of_run = 1'b1;
            n_points       = 2'd2;
        end
        else if (max_pos_next < min_pos_next)
        begin
            p0             = max_pt;
            p1             = min_pt;
            p1.last_of_run = 1'b1;
            n_points       = 2'd2;
        end
        else
        begin
            // both extremes at one position: send the minimum alone
            p0             = min_pt;
            p0.last_of_run = 1'b1;
            p1             = max_pt;
            n_points       = 2'd1;
        end
    end

    // ---------------- output buffer ----------------
    always_comb
    begin
        head_next   = head_reg;
        second_next = second_reg;
        if (push)
        begin
            head_next   = p0;
            second_next = p1;
        end
        else if (pop && (count_reg == 2'd2))
        begin
            head_next = second_reg;
        end
        count_next = count_reg - {1'b0, pop} + (push ? n_points : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg   <= head_next;
        second_reg <= second_next;
    end

    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tdata  = {head_reg.value, head_reg.position};
    assign m_axis_tlast  = head_reg.last_of_run;
    assign m_axis_tuser  = {head_reg.stream_done, head_reg.is_maximum};

endmodule
